/* hdl/i8080_pkg.sv */
package i8080_pkg;

    localparam int MEM_ADDR_BITS = 16;

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_EXEC  = 2'd2;
    localparam logic [1:0] REQ_RESET = 2'd3;

    // flag bit positions
    localparam int F_S  = 7;
    localparam int F_Z  = 6;
    localparam int F_AC = 4;
    localparam int F_P  = 2;
    localparam int F_C  = 0;

    // alu result bundle
    typedef struct packed {
        logic [7:0] res;
        logic [7:0] flg;
    } alu_out_t;

    // zero, sign, parity on a result
    function automatic logic [7:0] zsp(input logic [7:0] f, input logic [7:0] v);
        logic [7:0] r;
        r = f;
        r[F_Z] = (v == 8'd0);
        r[F_S] = v[7];
        r[F_P] = ~(^v);
        return r;
    endfunction

    // accumulator group operation
    function automatic alu_out_t alu_op(input logic [2:0] sel, input logic [7:0] a,
                                        input logic [7:0] v, input logic [7:0] f);
        alu_out_t o;
        logic [8:0] s;
        logic [4:0] h;
        logic       cy;
        cy = (sel == 3'd1 || sel == 3'd3) ? f[F_C] : 1'b0;
        o.res = a;
        o.flg = f;
        s = 9'd0;
        h = 5'd0;
        unique case (sel)
            3'd0, 3'd1:
            begin
                s = {1'b0, a} + {1'b0, v} + {8'd0, cy};
                h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, cy};
                o.res = s[7:0];
                o.flg = zsp(f, s[7:0]);
                o.flg[F_C] = s[8];
                o.flg[F_AC] = h[4];
            end
            3'd2, 3'd3, 3'd7:
            begin
                s = {1'b0, a} - {1'b0, v} - {8'd0, cy};
                h = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, cy};
                if (sel != 3'd7)
                begin
                    o.res = s[7:0];
                end
                o.flg = zsp(f, s[7:0]);
                o.flg[F_C] = s[8];
                o.flg[F_AC] = h[4];
            end
            3'd4:
            begin
                o.res = a & v;
                o.flg = zsp(f, a & v);
                o.flg[F_C] = 1'b0;
                o.flg[F_AC] = 1'b1;
            end
            3'd5:
            begin
                o.res = a ^ v;
                o.flg = zsp(f, a ^ v);
                o.flg[F_C] = 1'b0;
                o.flg[F_AC] = 1'b0;
            end
            3'd6:
            begin
                o.res = a | v;
                o.flg = zsp(f, a | v);
                o.flg[F_C] = 1'b0;
                o.flg[F_AC] = 1'b0;
            end
        endcase
        return o;
    endfunction

    // condition code test
    function automatic logic cond_ok(input logic [2:0] c, input logic [7:0] f);
        logic t;
        unique case (c[2:1])
            2'd0: t = f[F_Z];
            2'd1: t = f[F_C];
            2'd2: t = f[F_P];
            2'd3: t = f[F_S];
        endcase
        return c[0] ? t : ~t;
    endfunction

endpackage

/* hdl/intel8080_instruction_core_top.sv */
// sequencing: a load, a soft reset or a halted execute goes straight to the done state; a
// read waits in S_RDW for the memory; an instruction fetches its opcode, decodes, and takes
// each further byte read, or stored byte that is not its last step, through S_RD or S_STEP
// one beat at a time: no new beat is taken until the sequencer is idle; a stalled result
// holds off the next beat
// reset: rst_n clears registers, pc, halt and the sequencer; memory is undefined until written
module intel8080_instruction_core_top
    import i8080_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [15:0] mem_address,
    input  logic [7:0]  load_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_data,
    output logic [4:0]  cycle_count,
    output logic [15:0] program_counter,
    output logic [7:0]  accumulator_value,
    output logic [7:0]  flag_bits,
    output logic        halt_state
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_OPW   = 4'd1;  // opcode read in flight
    localparam logic [3:0] S_DEC   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;  // byte read in flight
    localparam logic [3:0] S_STEP  = 4'd4;  // act on read byte / next access
    localparam logic [3:0] S_DONE  = 4'd5;
    localparam logic [3:0] S_RDW   = 4'd6;  // read request wait

    logic [3:0]  state_reg, state_next;
    logic [7:0]  a_reg, a_next, f_reg, f_next;
    logic [7:0]  b_reg, c_reg, d_reg, e_reg, h_reg, l_reg;
    logic [7:0]  b_next, c_next, d_next, e_next, h_next, l_next;
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic        halt_reg, halt_next, ie_reg, ie_next;
    logic [7:0]  op_reg, op_next;
    logic [2:0]  ph_reg, ph_next;
    logic [15:0] t_reg, t_next;
    logic [4:0]  cyc_reg, cyc_next;
    logic [7:0]  rdb_reg, rdb_next;
    logic        ov_reg;
    logic [7:0]  o_rd_reg;
    logic [4:0]  o_cyc_reg;
    logic [15:0] o_pc_reg;
    logic [7:0]  o_a_reg, o_f_reg;
    logic        o_h_reg;

    logic        m_we;
    logic [15:0] m_addr;
    logic [7:0]  m_wd, m_rd;
    logic        take, done;

    i8080_ram #(.WIDTH(8), .DEPTH(1 << MEM_ADDR_BITS)) u_mem (
        .clk   (clk),
        .we    (m_we),
        .addr  (m_addr[MEM_ADDR_BITS-1:0]),
        .wdata (m_wd),
        .rdata (m_rd)
    );

    assign in_stall = (state_reg != S_IDLE) || (ov_reg && out_stall);
    assign take = in_valid && !in_stall;

    // decoded opcode fields
    logic [1:0] hi;
    logic [2:0] mid, lo;
    logic [1:0] rp;
    assign hi  = op_reg[7:6];
    assign mid = op_reg[5:3];
    assign lo  = op_reg[2:0];
    assign rp  = op_reg[5:4];

    // register file access helpers
    function automatic logic [7:0] rsel(input logic [2:0] r, input logic [7:0] bb,
        input logic [7:0] cc, input logic [7:0] dd, input logic [7:0] ee,
        input logic [7:0] hh, input logic [7:0] ll, input logic [7:0] aa,
        input logic [7:0] mm);
        logic [7:0] v;
        unique case (r)
            3'd0: v = bb;
            3'd1: v = cc;
            3'd2: v = dd;
            3'd3: v = ee;
            3'd4: v = hh;
            3'd5: v = ll;
            3'd6: v = mm;
            3'd7: v = aa;
        endcase
        return v;
    endfunction

    logic [15:0] hl, de, bc, pair;
    assign hl = {h_reg, l_reg};
    assign de = {d_reg, e_reg};
    assign bc = {b_reg, c_reg};
    always_comb
    begin
        unique case (rp)
            2'd0: pair = bc;
            2'd1: pair = de;
            2'd2: pair = hl;
            2'd3: pair = sp_reg;
        endcase
    end

    // sequencer: ph counts memory steps within one instruction
    always_comb
    begin
        logic [7:0]  src, v;
        logic [16:0] w;
        alu_out_t    ao;
        logic        mem_src;
        state_next = state_reg;
        a_next = a_reg; f_next = f_reg;
        b_next = b_reg; c_next = c_reg; d_next = d_reg;
        e_next = e_reg; h_next = h_reg; l_next = l_reg;
        sp_next = sp_reg; pc_next = pc_reg;
        halt_next = halt_reg; ie_next = ie_reg;
        op_next = op_reg; ph_next = ph_reg; t_next = t_reg;
        cyc_next = cyc_reg; rdb_next = rdb_reg;
        m_we = 1'b0; m_addr = pc_reg; m_wd = 8'd0;
        done = 1'b0;
        src = 8'd0; v = 8'd0; w = 17'd0; mem_src = 1'b0;
        ao = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    rdb_next = 8'd0;
                    cyc_next = 5'd0;
                    ph_next = 3'd0;
                    unique case (req_type)
                        REQ_LOAD:
                        begin
                            m_we = 1'b1; m_addr = mem_address; m_wd = load_data;
                            state_next = S_DONE;
                        end
                        REQ_READ:
                        begin
                            m_addr = mem_address;
                            state_next = S_RDW;
                        end
                        REQ_EXEC:
                        begin
                            if (halt_reg)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                m_addr = pc_reg;
                                pc_next = pc_reg + 16'd1;
                                state_next = S_OPW;
                            end
                        end
                        REQ_RESET:
                        begin
                            pc_next = 16'd0; halt_next = 1'b0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rdb_next = m_rd;
                state_next = S_DONE;
            end
            S_OPW:
            begin
                op_next = m_rd;
                state_next = S_DEC;
            end
            S_RD:
            begin
                rdb_next = m_rd;
                state_next = S_STEP;
            end
            S_DONE:
            begin
                done = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                // S_DEC when ph is 0 with no data, S_STEP otherwise; rdb holds last byte
                mem_src = (state_reg == S_STEP);
                state_next = S_DONE;
                if (hi == 2'd1)
                begin
                    if (op_reg == 8'h76)
                    begin
                        halt_next = 1'b1; cyc_next = 5'd7;
                    end
                    else if (lo == 3'd6 && !mem_src)
                    begin
                        m_addr = hl; state_next = S_RD;
                    end
                    else
                    begin
                        src = rsel(lo, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg,
                                   rdb_reg);
                        cyc_next = (mid == 3'd6 || lo == 3'd6) ? 5'd7 : 5'd5;
                        unique case (mid)
                            3'd0: b_next = src;
                            3'd1: c_next = src;
                            3'd2: d_next = src;
                            3'd3: e_next = src;
                            3'd4: h_next = src;
                            3'd5: l_next = src;
                            3'd6: begin m_we = 1'b1; m_addr = hl; m_wd = src; end
                            3'd7: a_next = src;
                        endcase
                    end
                end
                else if (hi == 2'd2 || (hi == 2'd3 && lo == 3'd6))
                begin
                    if ((hi == 2'd2 && lo == 3'd6 && !mem_src) || (hi == 2'd3 && !mem_src))
                    begin
                        m_addr = (hi == 2'd2) ? hl : pc_reg;
                        if (hi == 2'd3) pc_next = pc_reg + 16'd1;
                        state_next = S_RD;
                    end
                    else
                    begin
                        src = (hi == 2'd3) ? rdb_reg :
                              rsel(lo, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg, a_reg,
                                   rdb_reg);
                        ao = alu_op(mid, a_reg, src, f_reg);
                        a_next = ao.res; f_next = ao.flg;
                        cyc_next = (hi == 2'd3 || lo == 3'd6) ? 5'd7 : 5'd4;
                    end
                end
                else if (hi == 2'd0)
                begin
                    unique case (lo)
                        3'd0: cyc_next = 5'd4;
                        3'd1:
                        begin
                            if (!mid[0])
                            begin
                                // LXI: two immediate bytes
                                if (ph_reg == 3'd2)
                                begin
                                    cyc_next = 5'd10;
                                    unique case (rp)
                                        2'd0: begin b_next = rdb_reg; c_next = t_reg[7:0]; end
                                        2'd1: begin d_next = rdb_reg; e_next = t_reg[7:0]; end
                                        2'd2: begin h_next = rdb_reg; l_next = t_reg[7:0]; end
                                        2'd3: sp_next = {rdb_reg, t_reg[7:0]};
                                    endcase
                                end
                                else
                                begin
                                    if (ph_reg == 3'd1) t_next[7:0] = rdb_reg;
                                    m_addr = pc_reg; pc_next = pc_reg + 16'd1;
                                    ph_next = ph_reg + 3'd1; state_next = S_RD;
                                end
                            end
                            else
                            begin
                                w = {1'b0, hl} + {1'b0, pair};
                                h_next = w[15:8]; l_next = w[7:0];
                                f_next[F_C] = w[16];
                                cyc_next = 5'd10;
                            end
                        end
                        3'd2:
                        begin
                            if (!mid[2])
                            begin
                                cyc_next = 5'd7;
                                if (!mid[0])
                                begin
                                    m_we = 1'b1; m_addr = mid[1] ? de : bc; m_wd = a_reg;
                                end
                                else if (!mem_src)
                                begin
                                    m_addr = mid[1] ? de : bc; state_next = S_RD;
                                end
                                else
                                begin
                                    a_next = rdb_reg;
                                end
                            end
                            else
                            begin
                                // SHLD LHLD STA LDA: ph0,1 fetch addr; then data
                                if (ph_reg < 3'd2)
                                begin
                                    if (ph_reg == 3'd1) t_next[7:0] = rdb_reg;
                                    m_addr = pc_reg; pc_next = pc_reg + 16'd1;
                                    ph_next = ph_reg + 3'd1; state_next = S_RD;
                                end
                                else
                                begin
                                    if (ph_reg == 3'd2) t_next[15:8] = rdb_reg;
                                    unique case (mid[1:0])
                                        2'd0:
                                        begin
                                            m_we = 1'b1;
                                            if (ph_reg == 3'd2)
                                            begin
                                                m_addr = {rdb_reg, t_reg[7:0]}; m_wd = l_reg;
                                                ph_next = 3'd3; state_next = S_STEP;
                                            end
                                            else
                                            begin
                                                m_addr = t_reg + 16'd1; m_wd = h_reg;
                                                cyc_next = 5'd16;
                                            end
                                        end
                                        2'd1:
                                        begin
                                            if (ph_reg == 3'd2)
                                            begin
                                                m_addr = {rdb_reg, t_reg[7:0]};
                                                ph_next = 3'd3; state_next = S_RD;
                                            end
                                            else if (ph_reg == 3'd3)
                                            begin
                                                l_next = rdb_reg;
                                                m_addr = t_reg + 16'd1;
                                                ph_next = 3'd4; state_next = S_RD;
                                            end
                                            else
                                            begin
                                                h_next = rdb_reg; cyc_next = 5'd16;
                                            end
                                        end
                                        2'd2:
                                        begin
                                            m_we = 1'b1; m_addr = {rdb_reg, t_reg[7:0]};
                                            m_wd = a_reg; cyc_next = 5'd13;
                                        end
                                        2'd3:
                                        begin
                                            if (ph_reg == 3'd2)
                                            begin
                                                m_addr = {rdb_reg, t_reg[7:0]};
                                                ph_next = 3'd3; state_next = S_RD;
                                            end
                                            else
                                            begin
                                                a_next = rdb_reg; cyc_next = 5'd13;
                                            end
                                        end
                                    endcase
                                end
                            end
                        end
                        3'd3:
                        begin
                            cyc_next = 5'd5;
                            t_next = mid[0] ? pair - 16'd1 : pair + 16'd1;
                            unique case (rp)
                                2'd0: {b_next, c_next} = t_next;
                                2'd1: {d_next, e_next} = t_next;
                                2'd2: {h_next, l_next} = t_next;
                                2'd3: sp_next = t_next;
                            endcase
                        end
                        3'd4, 3'd5, 3'd6:
                        begin
                            if (mid == 3'd6 && lo != 3'd6 && !mem_src)
                            begin
                                m_addr = hl; state_next = S_RD;
                            end
                            else if (lo == 3'd6 && !mem_src)
                            begin
                                m_addr = pc_reg; pc_next = pc_reg + 16'd1;
                                state_next = S_RD;
                            end
                            else
                            begin
                                src = rsel(mid, b_reg, c_reg, d_reg, e_reg, h_reg, l_reg,
                                           a_reg, rdb_reg);
                                if (lo == 3'd6)
                                begin
                                    v = rdb_reg;
                                    cyc_next = (mid == 3'd6) ? 5'd10 : 5'd7;
                                end
                                else
                                begin
                                    v = (lo == 3'd4) ? src + 8'd1 : src - 8'd1;
                                    f_next = zsp(f_reg, v);
                                    f_next[F_AC] = (lo == 3'd4) ? (src[3:0] == 4'hF)
                                                                : (src[3:0] == 4'h0);
                                    cyc_next = (mid == 3'd6) ? 5'd10 : 5'd5;
                                end
                                unique case (mid)
                                    3'd0: b_next = v;
                                    3'd1: c_next = v;
                                    3'd2: d_next = v;
                                    3'd3: e_next = v;
                                    3'd4: h_next = v;
                                    3'd5: l_next = v;
                                    3'd6: begin m_we = 1'b1; m_addr = hl; m_wd = v; end
                                    3'd7: a_next = v;
                                endcase
                            end
                        end
                        3'd7:
                        begin
                            cyc_next = 5'd4;
                            unique case (mid)
                                3'd0: begin a_next = {a_reg[6:0], a_reg[7]}; f_next[F_C] = a_reg[7]; end
                                3'd1: begin a_next = {a_reg[0], a_reg[7:1]}; f_next[F_C] = a_reg[0]; end
                                3'd2: begin a_next = {a_reg[6:0], f_reg[F_C]}; f_next[F_C] = a_reg[7]; end
                                3'd3: begin a_next = {f_reg[F_C], a_reg[7:1]}; f_next[F_C] = a_reg[0]; end
                                3'd4:
                                begin
                                    v = 8'd0;
                                    if (f_reg[F_AC] || a_reg[3:0] > 4'd9) v[3:0] = 4'h6;
                                    if (f_reg[F_C] || a_reg > 8'h99) v[7:4] = 4'h6;
                                    ao = alu_op(3'd0, a_reg, v, f_reg);
                                    a_next = ao.res;
                                    f_next = ao.flg;
                                    f_next[F_C] = ao.flg[F_C] | f_reg[F_C] | (a_reg > 8'h99);
                                end
                                3'd5: a_next = ~a_reg;
                                3'd6: f_next[F_C] = 1'b1;
                                3'd7: f_next[F_C] = ~f_reg[F_C];
                            endcase
                        end
                    endcase
                end
                else
                begin
                    // hi == 3, lo != 6
                    unique case (lo)
                        3'd0, 3'd1:
                        begin
                            if (lo == 3'd1 && mid[0] && mid != 3'd1)
                            begin
                                cyc_next = (mid == 3'd3) ? 5'd4 : 5'd5;
                                if (mid == 3'd5) pc_next = hl;
                                if (mid == 3'd7) sp_next = hl;
                            end
                            else if (lo == 3'd0 && ph_reg == 3'd0 && !cond_ok(mid, f_reg))
                            begin
                                cyc_next = 5'd5;
                            end
                            else if (ph_reg < 3'd2)
                            begin
                                // pop two bytes
                                if (ph_reg == 3'd1) t_next[7:0] = rdb_reg;
                                m_addr = sp_reg; sp_next = sp_reg + 16'd1;
                                ph_next = ph_reg + 3'd1; state_next = S_RD;
                            end
                            else
                            begin
                                t_next = {rdb_reg, t_reg[7:0]};
                                if (lo == 3'd0)
                                begin
                                    pc_next = t_next; cyc_next = 5'd11;
                                end
                                else if (mid == 3'd1)
                                begin
                                    pc_next = t_next; cyc_next = 5'd10;
                                end
                                else
                                begin
                                    cyc_next = 5'd10;
                                    unique case (rp)
                                        2'd0: {b_next, c_next} = t_next;
                                        2'd1: {d_next, e_next} = t_next;
                                        2'd2: {h_next, l_next} = t_next;
                                        2'd3:
                                        begin
                                            f_next = (t_reg[7:0] & 8'hD7) | 8'h02;
                                            a_next = rdb_reg;
                                        end
                                    endcase
                                end
                            end
                        end
                        3'd3:
                        begin
                            unique case (mid)
                                3'd0, 3'd2, 3'd3:
                                begin
                                    if (ph_reg < 3'd2 && !(mid != 3'd0 && ph_reg == 3'd1))
                                    begin
                                        if (ph_reg == 3'd1) t_next[7:0] = rdb_reg;
                                        m_addr = pc_reg; pc_next = pc_reg + 16'd1;
                                        ph_next = ph_reg + 3'd1; state_next = S_RD;
                                    end
                                    else
                                    begin
                                        if (mid == 3'd0) pc_next = {rdb_reg, t_reg[7:0]};
                                        cyc_next = 5'd10;
                                    end
                                end
                                3'd4:
                                begin
                                    // XTHL: read sp, sp+1, write l, h
                                    unique case (ph_reg)
                                        3'd0:
                                        begin
                                            m_addr = sp_reg; ph_next = 3'd1; state_next = S_RD;
                                        end
                                        3'd1:
                                        begin
                                            t_next[7:0] = rdb_reg; m_addr = sp_reg + 16'd1;
                                            ph_next = 3'd2; state_next = S_RD;
                                        end
                                        3'd2:
                                        begin
                                            t_next[15:8] = rdb_reg;
                                            m_we = 1'b1; m_addr = sp_reg; m_wd = l_reg;
                                            ph_next = 3'd3; state_next = S_STEP;
                                        end
                                        default:
                                        begin
                                            m_we = 1'b1; m_addr = sp_reg + 16'd1; m_wd = h_reg;
                                            h_next = t_reg[15:8]; l_next = t_reg[7:0];
                                            cyc_next = 5'd18;
                                        end
                                    endcase
                                end
                                3'd5:
                                begin
                                    d_next = h_reg; e_next = l_reg;
                                    h_next = d_reg; l_next = e_reg;
                                    cyc_next = 5'd4;
                                end
                                3'd6: begin ie_next = 1'b0; cyc_next = 5'd4; end
                                3'd7: begin ie_next = 1'b1; cyc_next = 5'd4; end
                                default: cyc_next = 5'd4;
                            endcase
                        end
                        3'd2, 3'd4, 3'd5, 3'd7:
                        begin
                            // jumps and calls fetch an address; calls, push and rst push two bytes
                            if ((lo == 3'd5 && mid[0] && mid != 3'd1))
                            begin
                                cyc_next = 5'd4;
                            end
                            else if (lo != 3'd7 && !(lo == 3'd5 && !mid[0]) && ph_reg < 3'd2)
                            begin
                                if (ph_reg == 3'd1) t_next[7:0] = rdb_reg;
                                m_addr = pc_reg; pc_next = pc_reg + 16'd1;
                                ph_next = ph_reg + 3'd1; state_next = S_RD;
                            end
                            else if (lo == 3'd2)
                            begin
                                if (cond_ok(mid, f_reg)) pc_next = {rdb_reg, t_reg[7:0]};
                                cyc_next = 5'd10;
                            end
                            else if (lo == 3'd4 && ph_reg == 3'd2 && !cond_ok(mid, f_reg))
                            begin
                                cyc_next = 5'd11;
                            end
                            else
                            begin
                                // push: ph 2 (or 0) high byte, then low byte
                                if (ph_reg == 3'd2) t_next[15:8] = rdb_reg;
                                if (ph_reg == 3'd2 || ph_reg == 3'd0)
                                begin
                                    if (lo == 3'd5 && !mid[0])
                                        v = (rp == 2'd3) ? a_reg : pair[15:8];
                                    else
                                        v = pc_reg[15:8];
                                    m_we = 1'b1; m_addr = sp_reg - 16'd1; m_wd = v;
                                    sp_next = sp_reg - 16'd1;
                                    ph_next = 3'd5; state_next = S_STEP;
                                end
                                else
                                begin
                                    if (lo == 3'd5 && !mid[0])
                                        v = (rp == 2'd3) ? (f_reg | 8'h02) : pair[7:0];
                                    else
                                        v = pc_reg[7:0];
                                    m_we = 1'b1; m_addr = sp_reg - 16'd1; m_wd = v;
                                    sp_next = sp_reg - 16'd1;
                                    if (lo == 3'd7)
                                    begin
                                        pc_next = {10'd0, mid, 3'd0}; cyc_next = 5'd11;
                                    end
                                    else if (lo == 3'd5 && !mid[0])
                                    begin
                                        cyc_next = 5'd11;
                                    end
                                    else
                                    begin
                                        pc_next = t_reg; cyc_next = 5'd17;
                                    end
                                end
                            end
                        end
                        default: cyc_next = 5'd4;
                    endcase
                end
            end
        endcase
    end

    // architectural and sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            a_reg <= 8'd0; f_reg <= 8'd0;
            b_reg <= 8'd0; c_reg <= 8'd0; d_reg <= 8'd0;
            e_reg <= 8'd0; h_reg <= 8'd0; l_reg <= 8'd0;
            sp_reg <= 16'd0; pc_reg <= 16'd0;
            halt_reg <= 1'b0; ie_reg <= 1'b0;
            ph_reg <= 3'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_reg <= a_next; f_reg <= f_next;
            b_reg <= b_next; c_reg <= c_next; d_reg <= d_next;
            e_reg <= e_next; h_reg <= h_next; l_reg <= l_next;
            sp_reg <= sp_next; pc_reg <= pc_next;
            halt_reg <= halt_next; ie_reg <= ie_next;
            ph_reg <= ph_next;
            if (done)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        t_reg <= t_next;
        cyc_reg <= cyc_next;
        rdb_reg <= rdb_next;
        if (done)
        begin
            o_rd_reg  <= (cyc_reg == 5'd0) ? rdb_reg : 8'd0;
            o_cyc_reg <= cyc_reg;
            o_pc_reg  <= pc_reg;
            o_a_reg   <= a_reg;
            o_f_reg   <= f_reg;
            o_h_reg   <= halt_reg;
        end
    end

    assign out_valid         = ov_reg;
    assign read_data         = o_rd_reg;
    assign cycle_count       = o_cyc_reg;
    assign program_counter   = o_pc_reg;
    assign accumulator_value = o_a_reg;
    assign flag_bits         = o_f_reg;
    assign halt_state        = o_h_reg;

    // result only leaves the done state
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> out_valid)
        else $error("result lost");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("beat taken while busy");
    a_halt_cyc: assert property (@(posedge clk) disable iff (!rst_n)
        (take && req_type == REQ_EXEC && halt_reg) |=> !halt_reg || cyc_reg == 5'd0)
        else $error("halted execute counted cycles");

endmodule

/* hdl/i8080_ram.sv */
module i8080_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
